[src/boxcar_average_volume_scaler_assert.svh]
// Assertion macros used by the top module of the boxcar average block.
`ifndef BOXCAR_AVERAGE_VOLUME_SCALER_ASSERT_SVH
`define BOXCAR_AVERAGE_VOLUME_SCALER_ASSERT_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[src/bavs_pkg.sv]
`default_nettype none

package bavs_pkg;

  localparam int WINDOW_DEPTH = 10;

  localparam int SAMPLE_W     = 13;
  localparam int VOLUME_W     = 8;
  localparam int CFG_W        = 8;
  localparam int VOLUME_SHIFT = 5;

  localparam int SLOT_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int TOTAL_W = $clog2(WINDOW_DEPTH * 4096 + 1);
  localparam int CNT_W   = $clog2(TOTAL_W + 1);

  localparam logic [SAMPLE_W-1:0] SAMPLE_CEILING = SAMPLE_W'(4096);
  localparam logic [CFG_W-1:0]    CLAMP_RESET    = CFG_W'(1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_DIV,
    ST_DONE
  } bavs_state_t;

endpackage

`default_nettype wire

[src/bavs_in_if.sv]
`default_nettype none

interface bavs_in_if;
  import bavs_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

`default_nettype wire

[src/bavs_out_if.sv]
`default_nettype none

interface bavs_out_if;
  import bavs_pkg::*;

  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] average;
  logic [VOLUME_W-1:0] volume;

  modport source (output valid, output average, output volume, input ready);
  modport sink (input valid, input average, input volume, output ready);
endinterface

`default_nettype wire

[src/bavs_ram.sv]
`default_nettype none

module bavs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                         clk,
  input  wire logic                                         we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                             wdata,
  input  wire logic                                         re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[src/bavs_div.sv]
`default_nettype none

module bavs_div (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic [bavs_pkg::TOTAL_W-1:0]  dividend,
  input  wire logic [bavs_pkg::FILL_W-1:0]   divisor,
  output logic                               done,
  output logic      [bavs_pkg::TOTAL_W-1:0]  quotient
);
  import bavs_pkg::*;

  logic [CNT_W-1:0]   cnt;
  logic [TOTAL_W-1:0] work;
  logic [FILL_W-1:0]  rem;
  logic [FILL_W-1:0]  dsr;
  logic [FILL_W:0]    trial;
  logic               fits;

  // One restoring step per cycle: shift the next dividend bit into the remainder.
  assign trial = {rem, work[TOTAL_W-1]};
  assign fits  = trial >= {1'b0, dsr};
  assign done  = (cnt == CNT_W'(1));
  assign quotient = work;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(TOTAL_W);
    end else if (cnt != '0) begin
      cnt <= cnt - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (cnt != '0) begin
      work <= {work[TOTAL_W-2:0], fits};
      rem  <= fits ? FILL_W'(trial - {1'b0, dsr}) : FILL_W'(trial);
    end
  end

endmodule

`default_nettype wire

[src/boxcar_average_volume_scaler.sv]
// Boxcar average and volume scaler.
// The samples channel takes one converter reading per word; readings above
// 4096 are saturated to 4096. The results channel gives one word per sample:
// the truncated mean of the last ten readings (fewer while the window is
// still filling) and a volume of mean >> 5, forced to zero when it falls
// below the clamp threshold written on the configuration port.
// After a sample is accepted, the block reads the old window slot, updates
// the window and the running total, and runs the serial divider, which
// retires one quotient bit per cycle over the 16-bit running total; it then
// loads the output register. A new sample is taken only after that load.
// The result sits in an output register, so a new sample is taken while a
// result still waits. A stalled receiver holds the result; once the next
// result is ready, the block waits for the output register to empty.
// Reset empties the window, clears the running total and sets the clamp
// threshold to 1. Write the threshold only while no sample is in flight.
`default_nettype none

module boxcar_average_volume_scaler (
  input  wire logic                        clk,
  input  wire logic                        rst,
  bavs_in_if.sink                          samples,
  bavs_out_if.source                       results,
  input  wire logic                        cfg_wr_en,
  input  wire logic [bavs_pkg::CFG_W-1:0]  cfg_wr_data
);
  import bavs_pkg::*;

  `include "boxcar_average_volume_scaler_assert.svh"

  bavs_state_t         state;
  bavs_state_t         state_next;
  logic [SLOT_W-1:0]   write_slot;
  logic [SLOT_W-1:0]   write_slot_next;
  logic [FILL_W-1:0]   fill_count;
  logic [FILL_W-1:0]   fill_count_next;
  logic [TOTAL_W-1:0]  running_total;
  logic [TOTAL_W-1:0]  running_total_next;
  logic [CFG_W-1:0]    clamp_threshold;
  logic [SAMPLE_W-1:0] sample;
  logic [SAMPLE_W-1:0] sample_sat;
  logic [SAMPLE_W-1:0] old_sample;
  logic [SAMPLE_W-1:0] old_sub;
  logic                out_vld;
  logic [SAMPLE_W-1:0] average_reg;
  logic [VOLUME_W-1:0] volume_reg;

  logic                accept;
  logic                full;
  logic                ram_re;
  logic                ram_we;
  logic                div_start;
  logic                div_done;
  logic [TOTAL_W-1:0]  quotient;
  logic [SAMPLE_W-1:0] mean;
  logic [VOLUME_W-1:0] vol_raw;
  logic                out_load;

  assign samples.ready = (state == ST_IDLE);
  assign accept        = samples.valid && samples.ready;

  assign sample_sat = (samples.raw_sample > SAMPLE_CEILING) ? SAMPLE_CEILING
                                                             : samples.raw_sample;

  assign full    = (fill_count == FILL_W'(WINDOW_DEPTH));
  assign old_sub = full ? old_sample : '0;

  assign running_total_next = running_total - TOTAL_W'(old_sub) + TOTAL_W'(sample);
  assign fill_count_next    = full ? fill_count : FILL_W'(fill_count + 1'b1);
  assign write_slot_next    = (write_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0
                                                                        : SLOT_W'(write_slot + 1'b1);

  assign mean    = quotient[SAMPLE_W-1:0];
  assign vol_raw = VOLUME_W'(mean >> VOLUME_SHIFT);

  bavs_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (write_slot),
    .wdata (sample),
    .re    (ram_re),
    .raddr (write_slot),
    .rdata (old_sample)
  );

  bavs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_total_next),
    .divisor  (fill_count_next),
    .done     (div_done),
    .quotient (quotient)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_next = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld || results.ready) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_IDLE: begin
        ram_re = accept;
      end
      ST_UPDATE: begin
        ram_we    = 1'b1;
        div_start = 1'b1;
      end
      ST_DIV: begin
      end
      ST_DONE: begin
        out_load = !out_vld || results.ready;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      write_slot      <= '0;
      fill_count      <= '0;
      running_total   <= '0;
      clamp_threshold <= CLAMP_RESET;
      out_vld         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        clamp_threshold <= cfg_wr_data;
      end
      if (div_start) begin
        write_slot    <= write_slot_next;
        fill_count    <= fill_count_next;
        running_total <= running_total_next;
      end
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (results.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sample <= sample_sat;
    end
    if (out_load) begin
      average_reg <= mean;
      volume_reg  <= (vol_raw < clamp_threshold) ? '0 : vol_raw;
    end
  end

  assign results.valid   = out_vld;
  assign results.average = average_reg;
  assign results.volume  = volume_reg;

  `ASSERT_IMPLY(a_fill_bound, clk, rst, 1'b1, fill_count <= FILL_W'(WINDOW_DEPTH))
  `ASSERT_IMPLY(a_slot_bound, clk, rst, 1'b1, {1'b0, write_slot} < (SLOT_W + 1)'(WINDOW_DEPTH))
  `ASSERT_IMPLY(a_div_nonzero, clk, rst, div_start, fill_count_next != '0)
  `ASSERT_IMPLY(a_done_in_div, clk, rst, div_done, state == ST_DIV)
  `ASSERT_NEXT(a_load_valid, clk, rst, out_load, out_vld)

endmodule

`default_nettype wire

[test/average_checker.sv]
`default_nettype none

module average_checker
  import bavs_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  bavs_in_if                    samples,
  bavs_out_if                   results,
  input  wire logic             cfg_wr_en,
  input  wire logic [CFG_W-1:0] cfg_wr_data,
  output int                    fault_total,
  output int                    levels_pending
);

  typedef struct packed {
    logic [SAMPLE_W-1:0] average;
    logic [VOLUME_W-1:0] volume;
  } level_word_t;

  logic [SAMPLE_W-1:0] ring [WINDOW_DEPTH];
  int unsigned         slot;
  int unsigned         held;
  int unsigned         total;
  logic [CFG_W-1:0]    clamp;
  int                  faults = 0;
  level_word_t         expected_levels [$];

  function automatic level_word_t smooth_sample(input logic [SAMPLE_W-1:0] raw);
    logic [SAMPLE_W-1:0] clipped;
    int unsigned         mean;
    int unsigned         vol;
    level_word_t         w;
    clipped = (raw > SAMPLE_CEILING) ? SAMPLE_CEILING : raw;
    if (held == WINDOW_DEPTH) begin
      total -= ring[slot];
    end else begin
      held++;
    end
    ring[slot] = clipped;
    total += clipped;
    slot = (slot == WINDOW_DEPTH - 1) ? 0 : slot + 1;
    mean = total / held;
    vol = mean >> VOLUME_SHIFT;
    if (vol < clamp) begin
      vol = 0;
    end
    w.average = SAMPLE_W'(mean);
    w.volume = VOLUME_W'(vol);
    return w;
  endfunction

  task automatic log_fault(input string msg);
    faults++;
    if (faults <= 10) begin
      $display("%0t: %s", $time, msg);
    end
  endtask

  always @(posedge clk) begin
    level_word_t want;
    if (rst) begin
      slot = 0;
      held = 0;
      total = 0;
      clamp = CLAMP_RESET;
      expected_levels.delete();
    end else begin
      if (cfg_wr_en) begin
        clamp = cfg_wr_data;
      end
      if (results.valid && results.ready) begin
        if (expected_levels.size() == 0) begin
          log_fault($sformatf("unexpected word: average %0d volume %0d",
                              results.average, results.volume));
        end else begin
          want = expected_levels.pop_front();
          if (want.average !== results.average || want.volume !== results.volume) begin
            log_fault($sformatf("expected average %0d volume %0d, got average %0d volume %0d",
                                want.average, want.volume, results.average,
                                results.volume));
          end
        end
      end
      if (samples.valid && samples.ready) begin
        expected_levels.push_back(smooth_sample(samples.raw_sample));
      end
    end
    fault_total <= faults;
    levels_pending <= expected_levels.size();
  end

endmodule

`default_nettype wire

[test/tb.sv]
`default_nettype none

module tb;
  import bavs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int BURST_ITEMS = 163;
  localparam int PHASES      = 8;

  localparam logic [SAMPLE_W-1:0] WARMUP [10] = '{
    13'd4096, 13'd0, 13'd8191, 13'd4097, 13'd1,
    13'd31, 13'd32, 13'd4095, 13'h1555, 13'h0AAA
  };
  localparam logic [CFG_W-1:0] CLAMP_PLAN [5] = '{8'd0, 8'd128, 8'd129, 8'd255, 8'd4};

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_wr_en;
  logic [CFG_W-1:0] cfg_wr_data;
  int unsigned      send_gap_pct = 0;
  int unsigned      stall_pct = 0;
  int unsigned      level_center = 0;
  int               quiet_cycles = 0;
  int               mismatches;
  int               in_flight;

  bavs_in_if  samples ();
  bavs_out_if results ();

  boxcar_average_volume_scaler dut (
    .clk         (clk),
    .rst         (rst),
    .samples     (samples),
    .results     (results),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  average_checker checker_inst (
    .clk            (clk),
    .rst            (rst),
    .samples        (samples),
    .results        (results),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .fault_total    (mismatches),
    .levels_pending (in_flight)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    results.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int unsigned roll;
    int unsigned lo;
    roll = $urandom_range(0, 9);
    lo = (level_center > 96) ? level_center - 96 : 0;
    case (roll)
      0: begin
        case ($urandom_range(0, 2))
          0:       return '0;
          1:       return SAMPLE_CEILING;
          default: return '1;
        endcase
      end
      1, 2: begin
        return SAMPLE_W'($urandom_range(4097, 8191));
      end
      3, 4, 5: begin
        return SAMPLE_W'($urandom_range(lo, level_center + 96));
      end
      default: begin
        return SAMPLE_W'($urandom_range(0, 4096));
      end
    endcase
  endfunction

  task automatic send_sample(input logic [SAMPLE_W-1:0] value);
    if ($urandom_range(0, 99) < send_gap_pct) begin
      samples.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_gap_pct);
    end
    samples.valid <= 1'b1;
    samples.raw_sample <= value;
    do @(posedge clk); while (!samples.ready);
  endtask

  task automatic settle();
    samples.valid <= 1'b0;
    do @(posedge clk); while (in_flight != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [CFG_W-1:0] threshold;
    samples.valid <= 1'b0;
    samples.raw_sample <= '0;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Warm-up from an empty window, a full window of saturated words, then zeros and the ceiling.
    foreach (WARMUP[i]) begin
      send_sample(WARMUP[i]);
    end
    repeat (10) send_sample('1);
    repeat (3) send_sample('0);
    send_sample(SAMPLE_CEILING);
    settle();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0: begin
          send_gap_pct = 0;
          stall_pct = 0;
        end
        1: begin
          send_gap_pct = 65;
          stall_pct = 0;
        end
        2: begin
          send_gap_pct = 0;
          stall_pct = 65;
        end
        default: begin
          send_gap_pct = 13;
          stall_pct = 13;
        end
      endcase
      threshold = (p < 5) ? CLAMP_PLAN[p] : CFG_W'($urandom_range(0, 128));
      write_threshold(threshold);
      level_center = ((threshold > 128) ? $urandom_range(0, 128) : threshold) * 32;
      repeat (BURST_ITEMS) send_sample(pick_sample());
      settle();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
+incdir+src
src/bavs_pkg.sv
src/bavs_in_if.sv
src/bavs_out_if.sv
src/bavs_ram.sv
src/bavs_div.sv
src/boxcar_average_volume_scaler.sv
test/average_checker.sv
test/tb.sv
